@@ rtl/core/tte_pkg.sv @@
// Shared types and constants for the truncated time-of-day expander.
// No dependencies; every other file of the block but tte_ifs imports this package.
`timescale 1ns / 1ps
`default_nettype none

package tte_pkg;

    // Time of day in 1/128 s ticks
    localparam int unsigned TICK_W = 24;
    localparam logic [TICK_W-1:0] DAY_TICKS = 24'd11059200;
    localparam logic [TICK_W-1:0] DAY_MIDPOINT = 24'd5529600;
    // High byte of the last 65536-tick window that still lies inside the day
    localparam logic [7:0] TOP_HIGH = 8'hA8;

    // Seconds of day: (sec >> 7) / 675 by reciprocal, exact for 25-bit operands
    localparam logic [25:0] SEC_RECIP = 26'd50903317;
    localparam int unsigned SEC_SHIFT = 35;
    localparam logic [9:0] SEC_DIV_ODD = 10'd675;

    // Tick fraction: (ns >> 2) / 1953125 by reciprocal, exact for 28-bit operands
    localparam logic [28:0] NS_RECIP = 29'd288230377;
    localparam int unsigned NS_SHIFT = 49;
    localparam logic [29:0] NS_MAX = 30'd999999999;

    localparam logic signed [24:0] OFFSET_MAX = 25'sd11059199;

    typedef enum logic [0:0] {
        CFG_SOURCE_SYNC = 1'b0,
        CFG_AVG_OFFSET  = 1'b1
    } t_cfg_idx;

    // One report after local clock conversion
    typedef struct packed {
        logic              lsp_present;
        logic [15:0]       tod_low_part;
        logic [TICK_W-1:0] local_tick;
    } t_item;

    // Configuration seen by the back end
    typedef struct packed {
        logic               source_sync;
        logic signed [24:0] offset;
    } t_cfg;

endpackage

`default_nettype wire

@@ rtl/core/tte_ifs.sv @@
// Valid/ready channel interfaces for requests and results of the expander.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
`default_nettype none

interface tte_in_if;
    logic        valid;
    logic        ready;
    logic        lsp_present;
    logic [15:0] tod_low_part;
    logic [31:0] local_seconds;
    logic [29:0] local_nanoseconds;

    modport source (output valid, lsp_present, tod_low_part, local_seconds,
                    local_nanoseconds, input ready);
    modport sink (input valid, lsp_present, tod_low_part, local_seconds,
                  local_nanoseconds, output ready);
endinterface

interface tte_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [23:0] corrected_tod;

    modport source (output valid, accepted, corrected_tod, input ready);
    modport sink (input valid, accepted, corrected_tod, output ready);
endinterface

`default_nettype wire

@@ rtl/core/tte_front.sv @@
// Front end: accepts requests and converts the local clock to ticks of the day.
// Depends on tte_pkg and tte_in_if.
`timescale 1ns / 1ps
`default_nettype none

module tte_front (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    tte_in_if.sink       i_req,
    output tte_pkg::t_item o_item,
    output logic         o_item_valid,
    input  wire logic    i_item_ready
);
    import tte_pkg::*;

    logic [29:0] ns_clamped;
    logic [56:0] ns_prod;
    logic [50:0] sec_prod;
    logic        f1_take;
    logic        f2_take;

    logic        r_f1_v;
    logic [24:0] r_f1_sec_hi;
    logic [15:0] r_f1_q;
    logic [6:0]  r_f1_sec_lo;
    logic [6:0]  r_f1_frac;
    logic        r_f1_lsp;
    logic [15:0] r_f1_low;

    logic [25:0] sec_rem_full;
    t_item       n_f2_item;
    logic        r_f2_v;
    t_item       r_f2_item;

    // Stage 1: clamp nanoseconds, reciprocal multiplies
    always_comb begin
        ns_clamped = (i_req.local_nanoseconds > NS_MAX) ? NS_MAX : i_req.local_nanoseconds;
        ns_prod    = 57'(ns_clamped[29:2]) * 57'(NS_RECIP);
        sec_prod   = 51'(i_req.local_seconds[31:7]) * 51'(SEC_RECIP);
    end

    assign f2_take     = !r_f2_v || i_item_ready;
    assign f1_take     = !r_f1_v || f2_take;
    assign i_req.ready = f1_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (f1_take) begin
            r_f1_v <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f1_take && i_req.valid) begin
            r_f1_sec_hi <= i_req.local_seconds[31:7];
            r_f1_q      <= sec_prod[SEC_SHIFT+15:SEC_SHIFT];
            r_f1_sec_lo <= i_req.local_seconds[6:0];
            r_f1_frac   <= ns_prod[NS_SHIFT+6:NS_SHIFT];
            r_f1_lsp    <= i_req.lsp_present;
            r_f1_low    <= i_req.tod_low_part;
        end
    end

    // Stage 2: remainder of the odd factor, assemble ticks of the day
    always_comb begin
        sec_rem_full = 26'(r_f1_sec_hi) - 26'(r_f1_q) * 26'(SEC_DIV_ODD);
        n_f2_item.lsp_present  = r_f1_lsp;
        n_f2_item.tod_low_part = r_f1_low;
        n_f2_item.local_tick   = {sec_rem_full[9:0], r_f1_sec_lo, r_f1_frac};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (f2_take) begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f2_take && r_f1_v) begin
            r_f2_item <= n_f2_item;
        end
    end

    assign o_item_valid = r_f2_v;
    assign o_item       = r_f2_item;

endmodule

`default_nettype wire

@@ rtl/core/tte_queue.sv @@
// Short queue of converted requests between front and back end.
// Depends on tte_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tte_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    input  wire tte_pkg::t_item i_push_item,
    output logic               o_push_ready,
    output logic               o_pop_valid,
    output tte_pkg::t_item     o_pop_item,
    input  wire logic          i_pop_ready
);
    import tte_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tte_back.sv @@
// Back end: window expansion against the stored reference, offset correction.
// Depends on tte_pkg and tte_out_if.
`timescale 1ns / 1ps
`default_nettype none

module tte_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire tte_pkg::t_cfg  i_cfg,
    input  wire logic           i_item_valid,
    input  wire tte_pkg::t_item i_item,
    output logic                o_item_ready,
    tte_out_if.source           o_rsp
);
    import tte_pkg::*;

    function automatic logic [TICK_W-1:0] circ_dist(input logic [TICK_W-1:0] t,
                                                    input logic [TICK_W-1:0] rf);
        logic [TICK_W-1:0] d;
        begin
            d = (t > rf) ? (t - rf) : (rf - t);
            if (t >= DAY_TICKS) begin
                return DAY_TICKS;
            end
            return (d > DAY_MIDPOINT) ? (DAY_TICKS - d) : d;
        end
    endfunction

    logic [TICK_W-1:0] r_last;
    logic [TICK_W-1:0] ref_tick;
    logic [7:0]        high;
    logic [TICK_W-1:0] cand_same;
    logic [TICK_W-1:0] cand_below;
    logic [TICK_W-1:0] cand_above;
    logic [TICK_W-1:0] dist_same;
    logic [TICK_W-1:0] dist_below;
    logic [TICK_W-1:0] dist_above;
    logic [TICK_W-1:0] best;
    logic [TICK_W-1:0] best_dist;
    logic [TICK_W-1:0] n_tod;

    logic              out_take;
    logic              b1_take;
    logic              pop;

    logic              r_b1_v;
    logic              r_b1_acc;
    logic [TICK_W-1:0] r_b1_tod;

    logic signed [TICK_W+1:0] diff;
    logic [TICK_W-1:0]        n_corr;
    logic                     r_o_v;
    logic                     r_o_acc;
    logic [TICK_W-1:0]        r_o_tod;

    // Expand the low part against the reference; ties keep the same window, then below
    always_comb begin
        ref_tick   = (r_last != '0) ? r_last : i_item.local_tick;
        high       = ref_tick[23:16];
        cand_same  = {high, i_item.tod_low_part};
        cand_below = (high != '0) ? {high - 8'd1, i_item.tod_low_part}
                                  : {TOP_HIGH, i_item.tod_low_part};
        cand_above = (high < TOP_HIGH) ? {high + 8'd1, i_item.tod_low_part}
                                       : {8'd0, i_item.tod_low_part};
        dist_same  = circ_dist(cand_same, ref_tick);
        dist_below = circ_dist(cand_below, ref_tick);
        dist_above = circ_dist(cand_above, ref_tick);
        best       = cand_same;
        best_dist  = dist_same;
        if (dist_below < best_dist) begin
            best      = cand_below;
            best_dist = dist_below;
        end
        if (dist_above < best_dist) begin
            best = cand_above;
        end
        n_tod = i_item.lsp_present ? best : ref_tick;
    end

    assign out_take     = !r_o_v || o_rsp.ready;
    assign b1_take      = !r_b1_v || out_take;
    assign pop          = i_item_valid && b1_take;
    assign o_item_ready = b1_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= '0;
            r_b1_v <= 1'b0;
        end else begin
            if (pop && i_cfg.source_sync) begin
                r_last <= n_tod;
            end
            if (b1_take) begin
                r_b1_v <= i_item_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b1_acc <= i_cfg.source_sync;
            r_b1_tod <= i_cfg.source_sync ? n_tod : '0;
        end
    end

    // Subtract the offset with a single day wrap; rejected reports show zero
    always_comb begin
        diff = $signed({2'b00, r_b1_tod}) - (TICK_W + 2)'(i_cfg.offset);
        if (diff < 0) begin
            diff = diff + $signed({2'b00, DAY_TICKS});
        end else if (diff >= $signed({2'b00, DAY_TICKS})) begin
            diff = diff - $signed({2'b00, DAY_TICKS});
        end
        n_corr = r_b1_acc ? diff[TICK_W-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_v <= 1'b0;
        end else if (out_take) begin
            r_o_v <= r_b1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take && r_b1_v) begin
            r_o_acc <= r_b1_acc;
            r_o_tod <= n_corr;
        end
    end

    assign o_rsp.valid         = r_o_v;
    assign o_rsp.accepted      = r_o_acc;
    assign o_rsp.corrected_tod = r_o_tod;

endmodule

`default_nettype wire

@@ rtl/core/truncated_time_of_day_expander.sv @@
// Top level of the truncated time-of-day expander: configuration registers, front end,
// request queue and back end. Depends on tte_pkg, tte_ifs, tte_front, tte_queue, tte_back.
`timescale 1ns / 1ps
`default_nettype none

// Usage
//   i_req  : one report per request (lsp_present, tod_low_part, local clock).
//   o_rsp  : one result per request, in order: accepted and corrected_tod.
//   i_cfg_*: write source_synchronized (index 0) or average_offset (index 1)
//            while no request is in flight; the offset is saturated to
//            +/- one day less one tick as it is written.
// Throughput: one request per cycle while o_rsp.ready stays high. The only loop is the
//   stored reference, which the back end reads and updates in the same cycle.
// A request taken on i_req reaches o_rsp through two front stages (reciprocal
//   multiply for the seconds of day and tick fraction, then the remainder),
//   one queue slot, the expansion stage that updates the reference, and the
//   offset-correction output register.
// Stall: when o_rsp.ready is low the result holds, the back end stops
//   popping and the queue fills; i_req.ready drops only once the queue and
//   both front stages are full, so about QUEUE_DEPTH + 4 requests are absorbed.
// Reset (synchronous, active low) clears the stored reference (so the next
//   report uses the local clock), both configuration registers and all
//   valid flags; nothing is presented until a new request arrives.
module truncated_time_of_day_expander #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    tte_in_if.sink                 i_req,
    tte_out_if.source              o_rsp,
    input  wire logic              i_cfg_we,
    input  wire tte_pkg::t_cfg_idx i_cfg_idx,
    input  wire logic [24:0]       i_cfg_wdata
);
    import tte_pkg::*;

    logic               r_source_sync;
    logic signed [24:0] r_avg_offset;
    logic signed [24:0] offset_sat;
    t_cfg               cfg;

    t_item              front_item;
    logic               front_valid;
    logic               front_ready;
    t_item              queue_item;
    logic               queue_valid;
    logic               queue_ready;

    // Saturate the offset on write so the back end sees an in-range value
    always_comb begin
        offset_sat = $signed(i_cfg_wdata);
        if (offset_sat > OFFSET_MAX) begin
            offset_sat = OFFSET_MAX;
        end else if (offset_sat < -OFFSET_MAX) begin
            offset_sat = -OFFSET_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_sync <= 1'b0;
            r_avg_offset  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SOURCE_SYNC: begin
                    r_source_sync <= i_cfg_wdata[0];
                end
                CFG_AVG_OFFSET: begin
                    r_avg_offset <= offset_sat;
                end
                default: begin
                    r_source_sync <= r_source_sync;
                end
            endcase
        end
    end

    assign cfg.source_sync = r_source_sync;
    assign cfg.offset      = r_avg_offset;

    // Convert local clock to ticks of the day
    tte_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .o_item       (front_item),
        .o_item_valid (front_valid),
        .i_item_ready (front_ready)
    );

    // Decouple front and back so each can stall on its own
    tte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_item  (front_item),
        .o_push_ready (front_ready),
        .o_pop_valid  (queue_valid),
        .o_pop_item   (queue_item),
        .i_pop_ready  (queue_ready)
    );

    // Expand against the stored reference and apply the offset
    tte_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (queue_valid),
        .i_item       (queue_item),
        .o_item_ready (queue_ready),
        .o_rsp        (o_rsp)
    );

endmodule

`default_nettype wire

@@ rtl/core/tte_checker.sv @@
// Port-level checks of the expander and the bind that attaches them.
// Depends on tte_pkg and truncated_time_of_day_expander.
`timescale 1ns / 1ps
`default_nettype none

module tte_port_assert (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic        i_out_accepted,
    input wire logic [23:0] i_out_tod
);
    import tte_pkg::*;

    a_tod_in_day: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_tod < DAY_TICKS))
        else $error("corrected time of day outside the day");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_accepted) |-> (i_out_tod == '0))
        else $error("rejected report carries a non-zero time");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result presented straight after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_tod) && $stable(i_out_accepted)))
        else $error("stalled result changed");

endmodule

bind truncated_time_of_day_expander tte_port_assert u_tte_port_assert (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_out_accepted (o_rsp.accepted),
    .i_out_tod      (o_rsp.corrected_tod)
);

`default_nettype wire
